// ----- design/idf_pkg.sv -----
package idf_pkg;

    localparam int MAX_FIELD_DEF = 64;

    localparam int MAG_W      = 64;
    localparam int NDIG_MAX   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int QDEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION_GIVEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ALIGN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_MODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_FILL       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_KIND      = 3'd6;

    localparam logic [1:0] KIND_INT32  = 2'd0;
    localparam logic [1:0] KIND_INT16  = 2'd1;
    localparam logic [1:0] KIND_INT64  = 2'd2;
    localparam logic [1:0] KIND_UINT64 = 2'd3;

    localparam logic [1:0] SIGN_MINUS = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [6:0] pad_width;
        logic [5:0] min_digits;
        logic       precision_given;
        logic       left_align;
        logic [1:0] sign_mode;
        logic       zero_fill;
        logic [1:0] value_kind;
    } idf_cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [7:0]       sign_ch;
        logic             nodig;
    } idf_item_t;

endpackage

// ----- design/integer_decimal_formatter.sv -----
// a value goes from start through the queue, conversion and setup, then one character per cycle
// a value holds the converter through conversion, setup and n characters out (0 to 127);
// the conversion is a shift-add-3 binary to bcd pass over all 64 input bits
// a two-entry queue takes further values while one is converted; busy when it is full
// characters leave on strobe for one cycle each; the receiver cannot stall
// reset clears the config registers to zero, empties the queue and idles the converter
module integer_decimal_formatter
    import idf_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MAG_W-1:0]      value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  strobe,
    output logic [7:0]            ch,
    output logic                  empty_res,
    output logic                  last
);

    idf_cfg_t  cfg_reg;
    idf_item_t front_item;
    idf_item_t q_head;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    logic      push;

    assign busy = q_full;
    assign push = start && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAD_WIDTH:       cfg_reg.pad_width       <= cfg_data;
                REG_MIN_DIGITS:      cfg_reg.min_digits      <= cfg_data[5:0];
                REG_PRECISION_GIVEN: cfg_reg.precision_given <= cfg_data[0];
                REG_LEFT_ALIGN:      cfg_reg.left_align      <= cfg_data[0];
                REG_SIGN_MODE:       cfg_reg.sign_mode       <= cfg_data[1:0];
                REG_ZERO_FILL:       cfg_reg.zero_fill       <= cfg_data[0];
                REG_VALUE_KIND:      cfg_reg.value_kind      <= cfg_data[1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    idf_front u_front (
        .cfg   (cfg_reg),
        .value (value),
        .item  (front_item)
    );

    idf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    idf_back #(
        .MAX_FIELD (MAX_FIELD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .strobe    (strobe),
        .ch        (ch),
        .empty_res (empty_res),
        .last      (last)
    );

endmodule

// ----- design/idf_front.sv -----
module idf_front
    import idf_pkg::*;
(
    input  idf_cfg_t         cfg,
    input  logic [MAG_W-1:0] value,
    output idf_item_t        item
);

    logic             is_signed;
    logic             neg;
    logic [MAG_W-1:0] low_bits;
    logic [MAG_W-1:0] mag;

    always_comb
    begin
        is_signed = (cfg.value_kind != KIND_UINT64);
        neg       = 1'b0;
        low_bits  = value;
        mag       = value;
        unique case (cfg.value_kind)
            KIND_INT32:
            begin
                neg      = value[31];
                low_bits = {32'd0, value[31:0]};
                mag      = neg ? (64'h1_0000_0000 - low_bits) : low_bits;
            end
            KIND_INT16:
            begin
                neg      = value[15];
                low_bits = {48'd0, value[15:0]};
                mag      = neg ? (64'h1_0000 - low_bits) : low_bits;
            end
            KIND_INT64:
            begin
                neg = value[MAG_W-1];
                mag = neg ? (64'd0 - value) : value;
            end
            default:
            begin
                mag = value;
            end
        endcase

        item.mag = mag;
        if (neg)
        begin
            item.sign_ch = CH_MINUS;
        end
        else if (is_signed && cfg.sign_mode == SIGN_PLUS)
        begin
            item.sign_ch = CH_PLUS;
        end
        else if (is_signed && cfg.sign_mode == SIGN_SPACE)
        begin
            item.sign_ch = CH_SPACE;
        end
        else
        begin
            item.sign_ch = CH_NONE;
        end
        // signed zero with explicit zero precision prints no digits
        item.nodig = is_signed && (mag == '0) && cfg.precision_given
                     && (cfg.min_digits == 6'd0);
    end

endmodule

// ----- design/idf_queue.sv -----
module idf_queue
    import idf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  idf_item_t push_item,
    input  logic      pop,
    output idf_item_t head,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    idf_item_t        entries_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("transfer pushed into a full queue");

endmodule

// ----- design/idf_back.sv -----
module idf_back
    import idf_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  idf_cfg_t  cfg,
    input  logic      q_empty,
    input  idf_item_t q_head,
    output logic      q_pop,
    output logic      strobe,
    output logic [7:0] ch,
    output logic      empty_res,
    output logic      last
);

    localparam int WMAX  = (MAX_FIELD > 127) ? 127 : MAX_FIELD;
    localparam int PMAX  = (MAX_FIELD - 1 > 63) ? 63 : MAX_FIELD - 1;
    localparam logic [6:0] WMAX_C = 7'(WMAX);
    localparam logic [5:0] PMAX_C = 6'(PMAX);

    localparam int BIT_W = $clog2(MAG_W);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(MAG_W - 1);
    localparam int DIG_W = $clog2(NDIG_MAX + 1);
    localparam logic [DIG_W-1:0] NDIG_C = DIG_W'(NDIG_MAX);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_SETUP = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]       state_reg;
    logic [MAG_W-1:0] shreg_reg;
    logic [3:0]       bcd_reg [NDIG_MAX];
    logic [3:0]       bcd_adj [NDIG_MAX];
    logic [3:0]       bcd_next [NDIG_MAX];
    logic [DIG_W-1:0] ndig_reg;
    logic [BIT_W-1:0] bitcnt_reg;
    logic [7:0]       sign_reg;
    logic             nodig_reg;
    logic [6:0]       lpad_reg;
    logic [6:0]       zcnt_reg;
    logic [6:0]       rpad_reg;
    logic [6:0]       rem_reg;
    logic             sign_pend_reg;
    logic [DIG_W-1:0] dig_cnt_reg;
    logic             strobe_reg;
    logic [7:0]       ch_reg;
    logic             empty_reg;
    logic             last_reg;

    logic             grow;
    logic [DIG_W-1:0] nd;
    logic [6:0]       width7;
    logic [5:0]       prec6;
    logic [6:0]       zeros7;
    logic             has_sign;
    logic [6:0]       body7;
    logic [6:0]       pad7;
    logic [6:0]       total7;
    logic             uzp;
    logic [DIG_W-1:0] dig_idx;
    logic [7:0]       emit_ch;
    logic [1:0]       emit_sel;

    localparam logic [1:0] E_LPAD = 2'd0;
    localparam logic [1:0] E_SIGN = 2'd1;
    localparam logic [1:0] E_ZERO = 2'd2;
    localparam logic [1:0] E_TAIL = 2'd3;

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign strobe    = strobe_reg;
    assign ch        = ch_reg;
    assign empty_res = empty_reg;
    assign last      = last_reg;

    // shift-add-3 binary to bcd, one input bit per cycle
    always_comb
    begin
        for (int i = 0; i < NDIG_MAX; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        bcd_next[0] = {bcd_adj[0][2:0], shreg_reg[MAG_W-1]};
        for (int i = 1; i < NDIG_MAX; i++)
        begin
            bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
        end
        // a shift can only light up the digit just above the current top
        grow = 1'b0;
        if (ndig_reg < NDIG_C)
        begin
            grow = (bcd_next[ndig_reg[DIG_W-1:0]] != 4'd0);
        end
    end

    always_comb
    begin
        if (nodig_reg)
        begin
            nd = '0;
        end
        else if (ndig_reg == '0)
        begin
            nd = DIG_W'(1);
        end
        else
        begin
            nd = ndig_reg;
        end
        width7   = (cfg.pad_width > WMAX_C) ? WMAX_C : cfg.pad_width;
        prec6    = (cfg.min_digits > PMAX_C) ? PMAX_C : cfg.min_digits;
        zeros7   = ({1'b0, prec6} > 7'(nd)) ? ({1'b0, prec6} - 7'(nd)) : 7'd0;
        has_sign = (sign_reg != CH_NONE);
        body7    = 7'(has_sign) + zeros7 + 7'(nd);
        pad7     = (width7 > body7) ? (width7 - body7) : 7'd0;
        total7   = pad7 + body7;
        uzp      = cfg.zero_fill && !cfg.left_align && !cfg.precision_given;
    end

    always_comb
    begin
        dig_idx = dig_cnt_reg - 1'b1;
        if (lpad_reg != '0)
        begin
            emit_sel = E_LPAD;
        end
        else if (sign_pend_reg)
        begin
            emit_sel = E_SIGN;
        end
        else if (zcnt_reg != '0)
        begin
            emit_sel = E_ZERO;
        end
        else
        begin
            emit_sel = E_TAIL;
        end
        emit_ch = CH_SPACE;
        case (emit_sel)
            E_LPAD: emit_ch = CH_SPACE;
            E_SIGN: emit_ch = sign_reg;
            E_ZERO: emit_ch = CH_ZERO;
            default:
            begin
                if (dig_cnt_reg != '0)
                begin
                    emit_ch = CH_ZERO | {4'd0, bcd_reg[dig_idx]};
                end
                else
                begin
                    emit_ch = CH_SPACE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            shreg_reg <= q_head.mag;
            sign_reg  <= q_head.sign_ch;
            nodig_reg <= q_head.nodig;
            for (int i = 0; i < NDIG_MAX; i++)
            begin
                bcd_reg[i] <= 4'd0;
            end
        end
        else if (state_reg == S_CONV)
        begin
            shreg_reg <= {shreg_reg[MAG_W-2:0], 1'b0};
            for (int i = 0; i < NDIG_MAX; i++)
            begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
        if (state_reg == S_SETUP && total7 == '0)
        begin
            ch_reg    <= CH_NONE;
            empty_reg <= 1'b1;
            last_reg  <= 1'b1;
        end
        else
        begin
            ch_reg    <= emit_ch;
            empty_reg <= 1'b0;
            last_reg  <= (rem_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ndig_reg      <= '0;
            bitcnt_reg    <= '0;
            lpad_reg      <= '0;
            zcnt_reg      <= '0;
            rpad_reg      <= '0;
            rem_reg       <= '0;
            sign_pend_reg <= 1'b0;
            dig_cnt_reg   <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    strobe_reg <= 1'b0;
                    if (!q_empty)
                    begin
                        ndig_reg   <= '0;
                        bitcnt_reg <= '0;
                        state_reg  <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    strobe_reg <= 1'b0;
                    if (grow)
                    begin
                        ndig_reg <= ndig_reg + 1'b1;
                    end
                    bitcnt_reg <= bitcnt_reg + 1'b1;
                    if (bitcnt_reg == BIT_LAST)
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    lpad_reg      <= (!cfg.left_align && !uzp) ? pad7 : 7'd0;
                    zcnt_reg      <= (uzp ? pad7 : 7'd0) + zeros7;
                    rpad_reg      <= cfg.left_align ? pad7 : 7'd0;
                    sign_pend_reg <= has_sign;
                    dig_cnt_reg   <= nd;
                    rem_reg       <= total7;
                    if (total7 == '0)
                    begin
                        strobe_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        strobe_reg <= 1'b0;
                        state_reg  <= S_EMIT;
                    end
                end
                default:
                begin
                    strobe_reg <= 1'b1;
                    rem_reg    <= rem_reg - 1'b1;
                    case (emit_sel)
                        E_LPAD: lpad_reg <= lpad_reg - 1'b1;
                        E_SIGN: sign_pend_reg <= 1'b0;
                        E_ZERO: zcnt_reg <= zcnt_reg - 1'b1;
                        default:
                        begin
                            if (dig_cnt_reg != '0)
                            begin
                                dig_cnt_reg <= dig_cnt_reg - 1'b1;
                            end
                            else
                            begin
                                rpad_reg <= rpad_reg - 1'b1;
                            end
                        end
                    endcase
                    if (rem_reg == 7'd1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> rem_reg != '0)
        else $error("emitting with no characters left");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && rem_reg == 7'd1)
        |=> (strobe_reg && last_reg && state_reg == S_IDLE))
        else $error("final character did not close the value");

    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONV |-> ndig_reg <= NDIG_C)
        else $error("digit count overflow");

endmodule
